// ----- design/kdec_pkg.sv -----
// ----------------------------------------------------------------------------
// kdec_pkg
// Shared types and constants for the key debounce event counter.
// ----------------------------------------------------------------------------
package kdec_pkg;

  localparam int TICK_WIDTH_DEFAULT = 16;

  // configuration register file
  localparam int CFG_W       = 16;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [CFG_W-1:0] HOLD_RESET     = 16'd1000;

  localparam int COUNT_W = 8;

  typedef enum logic {
    REG_DEBOUNCE = 1'b0,
    REG_HOLD     = 1'b1
  } kdec_reg_t;

  typedef enum logic [1:0] {
    MODE_TICK         = 2'd0,
    MODE_READ_PRESS   = 2'd1,
    MODE_READ_RELEASE = 2'd2,
    MODE_READ_TIMEOUT = 2'd3
  } kdec_mode_t;

  // one result transfer
  typedef struct packed {
    logic [1:0]         key_state;
    logic [COUNT_W-1:0] read_value;
    logic [COUNT_W-1:0] press_events;
    logic [COUNT_W-1:0] release_events;
    logic [COUNT_W-1:0] timeout_events;
  } kdec_result_t;

endpackage

// ----- design/kdec_cfg.sv -----
// ----------------------------------------------------------------------------
// kdec_cfg
// APB-style register file holding the debounce and hold tick limits.
// ----------------------------------------------------------------------------
module kdec_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [kdec_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [kdec_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [kdec_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [kdec_pkg::CFG_W-1:0]       debounce_ticks,
  output logic [kdec_pkg::CFG_W-1:0]       hold_ticks
);

  kdec_pkg::kdec_reg_t reg_sel;
  logic                wr_en;

  assign pready  = 1'b1;
  assign reg_sel = kdec_pkg::kdec_reg_t'(paddr[kdec_pkg::APB_ADDR_W-1]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= kdec_pkg::DEBOUNCE_RESET;
      hold_ticks     <= kdec_pkg::HOLD_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        kdec_pkg::REG_DEBOUNCE: debounce_ticks <= pwdata[kdec_pkg::CFG_W-1:0];
        kdec_pkg::REG_HOLD:     hold_ticks     <= pwdata[kdec_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      kdec_pkg::REG_DEBOUNCE:
        prdata = kdec_pkg::APB_DATA_W'(debounce_ticks);
      kdec_pkg::REG_HOLD:
        prdata = kdec_pkg::APB_DATA_W'(hold_ticks);
      default:
        prdata = '0;
    endcase
  end

endmodule

// ----- design/kdec_core.sv -----
// ----------------------------------------------------------------------------
// kdec_core
// Four-phase debounce machine with press, release and timeout counters.
// Next state and result are combinational; state commits on step.
// ----------------------------------------------------------------------------
module kdec_core #(
  parameter int TICK_WIDTH = kdec_pkg::TICK_WIDTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [1:0]                  mode,
  input  logic                        pin_level,
  input  logic [kdec_pkg::CFG_W-1:0]  debounce_ticks,
  input  logic [kdec_pkg::CFG_W-1:0]  hold_ticks,
  output kdec_pkg::kdec_result_t      res
);

  localparam int CMP_W = (TICK_WIDTH > kdec_pkg::CFG_W) ? TICK_WIDTH : kdec_pkg::CFG_W;

  typedef enum logic [1:0] {
    PH_RELEASED  = 2'd0,
    PH_PRESSING  = 2'd1,
    PH_PRESSED   = 2'd2,
    PH_RELEASING = 2'd3
  } phase_t;

  phase_t                         phase, phase_next;
  logic [TICK_WIDTH-1:0]          tick_count, tick_count_next;
  logic [TICK_WIDTH-1:0]          mark_count, mark_count_next;
  logic [kdec_pkg::COUNT_W-1:0]   press_total, press_total_next;
  logic [kdec_pkg::COUNT_W-1:0]   release_total, release_total_next;
  logic [kdec_pkg::COUNT_W-1:0]   timeout_total, timeout_total_next;
  logic [kdec_pkg::COUNT_W-1:0]   read_value;
  logic                           down;
  kdec_pkg::kdec_mode_t           mode_e;

  // signed span test: a negative difference never counts as held
  function automatic logic held(input logic [TICK_WIDTH-1:0]      t,
                                input logic [TICK_WIDTH-1:0]      m,
                                input logic [kdec_pkg::CFG_W-1:0] lim);
    logic [TICK_WIDTH-1:0] diff;
    diff = t - m;
    return !diff[TICK_WIDTH-1] && (CMP_W'(diff) >= CMP_W'(lim));
  endfunction

  assign down   = !pin_level;
  assign mode_e = kdec_pkg::kdec_mode_t'(mode);

  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    mark_count_next    = mark_count;
    press_total_next   = press_total;
    release_total_next = release_total;
    timeout_total_next = timeout_total;
    read_value         = '0;

    case (mode_e)
      kdec_pkg::MODE_TICK: begin
        unique case (phase)
          PH_RELEASED: begin
            if (down) begin
              mark_count_next = tick_count;
              phase_next      = PH_PRESSING;
            end else begin
              tick_count_next = '0;
              mark_count_next = '0;
            end
          end
          PH_PRESSING: begin
            if (down) tick_count_next = tick_count + TICK_WIDTH'(1);
            else      phase_next      = PH_RELEASED;
            if (held(tick_count_next, mark_count_next, debounce_ticks)) begin
              press_total_next = press_total + 1'b1;
              tick_count_next  = '0;
              mark_count_next  = '0;
              phase_next       = PH_PRESSED;
            end
          end
          PH_PRESSED: begin
            if (down) begin
              tick_count_next = tick_count + TICK_WIDTH'(1);
            end else begin
              tick_count_next = '0;
              mark_count_next = '0;
              phase_next      = PH_RELEASING;
            end
            if (CMP_W'(tick_count_next) >= CMP_W'(hold_ticks)) begin
              timeout_total_next = timeout_total + 1'b1;
              tick_count_next    = '0;
            end
          end
          PH_RELEASING: begin
            if (!down) begin
              tick_count_next = tick_count + TICK_WIDTH'(1);
            end else begin
              phase_next      = PH_PRESSED;
              mark_count_next = tick_count;
              tick_count_next = '0;
            end
            if (held(tick_count_next, mark_count_next, debounce_ticks)) begin
              release_total_next = release_total + 1'b1;
              tick_count_next    = '0;
              mark_count_next    = '0;
              phase_next         = PH_RELEASED;
            end
          end
          default: begin
            phase_next         = PH_RELEASED;
            tick_count_next    = '0;
            mark_count_next    = '0;
            press_total_next   = '0;
            release_total_next = '0;
            timeout_total_next = '0;
          end
        endcase
      end
      kdec_pkg::MODE_READ_PRESS: begin
        read_value       = press_total;
        press_total_next = '0;
      end
      kdec_pkg::MODE_READ_RELEASE: begin
        read_value         = release_total;
        release_total_next = '0;
      end
      default: begin
        read_value         = timeout_total;
        timeout_total_next = '0;
      end
    endcase
  end

  always_comb begin
    res.key_state      = phase_next;
    res.read_value     = read_value;
    res.press_events   = press_total_next;
    res.release_events = release_total_next;
    res.timeout_events = timeout_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_RELEASED;
      tick_count    <= '0;
      mark_count    <= '0;
      press_total   <= '0;
      release_total <= '0;
      timeout_total <= '0;
    end else if (step) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      mark_count    <= mark_count_next;
      press_total   <= press_total_next;
      release_total <= release_total_next;
      timeout_total <= timeout_total_next;
    end
  end

endmodule

// ----- design/key_debounce_event_counter_top.sv -----
// ----------------------------------------------------------------------------
// key_debounce_event_counter_top
// Debounced push-button event counter with read-clear event counts.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+--------------------------------
//   item     | item_valid / item_stall    | mode, pin_level
//   result   | result_valid / result_stall| key_state, read_value,
//            |                            | press_events, release_events,
//            |                            | timeout_events
//   config   | APB psel/penable/pwrite    | paddr, pwdata, prdata
//
// One item per cycle while item_stall is low; each item passes the input
// register, then the result register. Debounce state commits as the
// item moves into the result register. Synchronous reset clears valid
// flags and debounce state and loads the default tick limits. A stalled
// result holds the input register; item_stall follows once it is full.
// ----------------------------------------------------------------------------
module key_debounce_event_counter_top #(
  parameter int TICK_WIDTH = kdec_pkg::TICK_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [1:0]                       mode,
  input  logic                             pin_level,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [1:0]                       key_state,
  output logic [kdec_pkg::COUNT_W-1:0]     read_value,
  output logic [kdec_pkg::COUNT_W-1:0]     press_events,
  output logic [kdec_pkg::COUNT_W-1:0]     release_events,
  output logic [kdec_pkg::COUNT_W-1:0]     timeout_events,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [kdec_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [kdec_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [kdec_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  logic                         in_full;
  logic [1:0]                   in_mode;
  logic                         in_pin;
  logic                         advance;
  logic                         step;
  logic [kdec_pkg::CFG_W-1:0]   debounce_ticks;
  logic [kdec_pkg::CFG_W-1:0]   hold_ticks;
  kdec_pkg::kdec_result_t       res;

  assign advance    = !result_valid || !result_stall;
  assign step       = in_full && advance;
  assign item_stall = in_full && !advance;

  kdec_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .debounce_ticks (debounce_ticks),
    .hold_ticks     (hold_ticks)
  );

  kdec_core #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .mode           (in_mode),
    .pin_level      (in_pin),
    .debounce_ticks (debounce_ticks),
    .hold_ticks     (hold_ticks),
    .res            (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!item_stall) begin
      in_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_mode <= mode;
      in_pin  <= pin_level;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      key_state      <= res.key_state;
      read_value     <= res.read_value;
      press_events   <= res.press_events;
      release_events <= res.release_events;
      timeout_events <= res.timeout_events;
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the key debounce event counter. A table of
// directed items and register writes runs first, then a run of short press
// cycles that wraps all three event counts, then randomized phases of
// press/release sequences with bounces, reads and noise under several tick
// limits, including the largest ones. Every result transfer is checked
// against a cycle-free model of the debounce machine kept in this bench.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kdec_pkg::*;

  localparam int TW = TICK_WIDTH_DEFAULT;
  localparam int CYCLE_LIMIT = 50_000;

  typedef enum logic [1:0] {
    KS_RELEASED  = 2'd0,
    KS_PRESSING  = 2'd1,
    KS_PRESSED   = 2'd2,
    KS_RELEASING = 2'd3
  } key_state_t;

  typedef struct {
    bit           is_cfg;
    bit           known;
    kdec_mode_t   m;
    logic         pin;
    kdec_reg_t    r;
    logic [15:0]  v;
    kdec_result_t want;
  } dir_row_t;

  typedef struct {
    int debounce;
    int hold;
    int items;
    int read_pct;
    bit calm;
  } phase_plan_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  logic [1:0]            mode = MODE_TICK;
  logic                  pin_level = 1'b1;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [1:0]            key_state;
  logic [COUNT_W-1:0]    read_value;
  logic [COUNT_W-1:0]    press_events;
  logic [COUNT_W-1:0]    release_events;
  logic [COUNT_W-1:0]    timeout_events;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // debounce model state and its copy of the tick limits
  key_state_t    key_ph;
  logic [TW-1:0] tick_cnt;
  logic [TW-1:0] mark_cnt;
  logic [7:0]    n_press;
  logic [7:0]    n_release;
  logic [7:0]    n_timeout;
  logic [15:0]   cfg_debounce;
  logic [15:0]   cfg_hold;

  kdec_result_t expected_results[$];
  int           mismatches = 0;
  int           cycle_count = 0;
  bit           calm = 1'b0;

  key_debounce_event_counter_top dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .mode           (mode),
    .pin_level      (pin_level),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .key_state      (key_state),
    .read_value     (read_value),
    .press_events   (press_events),
    .release_events (release_events),
    .timeout_events (timeout_events),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // signed level test: a negative difference never counts as settled
  function automatic logic level_settled();
    logic [TW-1:0] d;
    d = tick_cnt - mark_cnt;
    return !d[TW-1] && (d >= cfg_debounce);
  endfunction

  function automatic kdec_result_t predict_step(input kdec_mode_t m, input logic pin);
    kdec_result_t res;
    logic         down;
    res = '0;
    down = !pin;
    case (m)
      MODE_TICK: begin
        case (key_ph)
          KS_RELEASED: begin
            if (down) begin
              mark_cnt = tick_cnt;
              key_ph = KS_PRESSING;
            end else begin
              tick_cnt = '0;
              mark_cnt = '0;
            end
          end
          KS_PRESSING: begin
            if (down) tick_cnt = tick_cnt + 1'b1;
            else key_ph = KS_RELEASED;
            if (level_settled()) begin
              n_press = n_press + 1'b1;
              tick_cnt = '0;
              mark_cnt = '0;
              key_ph = KS_PRESSED;
            end
          end
          KS_PRESSED: begin
            if (down) begin
              tick_cnt = tick_cnt + 1'b1;
            end else begin
              tick_cnt = '0;
              mark_cnt = '0;
              key_ph = KS_RELEASING;
            end
            if (tick_cnt >= cfg_hold) begin
              n_timeout = n_timeout + 1'b1;
              tick_cnt = '0;
            end
          end
          default: begin
            if (!down) begin
              tick_cnt = tick_cnt + 1'b1;
            end else begin
              key_ph = KS_PRESSED;
              mark_cnt = tick_cnt;
              tick_cnt = '0;
            end
            if (level_settled()) begin
              n_release = n_release + 1'b1;
              tick_cnt = '0;
              mark_cnt = '0;
              key_ph = KS_RELEASED;
            end
          end
        endcase
      end
      MODE_READ_PRESS: begin
        res.read_value = n_press;
        n_press = '0;
      end
      MODE_READ_RELEASE: begin
        res.read_value = n_release;
        n_release = '0;
      end
      default: begin
        res.read_value = n_timeout;
        n_timeout = '0;
      end
    endcase
    res.key_state = key_ph;
    res.press_events = n_press;
    res.release_events = n_release;
    res.timeout_events = n_timeout;
    return res;
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("ERROR @%0t %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // one item transfer; the expectation is queued at the accepting edge
  task automatic push_item(input kdec_mode_t m, input logic pin,
                           input bit known = 1'b0, input kdec_result_t want = '0);
    kdec_result_t pred;
    while (!calm && $urandom_range(0, 99) < 26) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    mode <= m;
    pin_level <= pin;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pred = predict_step(m, pin);
    expected_results.push_back(known ? want : pred);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input kdec_reg_t r, input logic [15:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(int'(r) * 4);
    pwdata <= APB_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (r == REG_DEBOUNCE) cfg_debounce = v;
    else cfg_hold = v;
  endtask

  function automatic dir_row_t item_row(input kdec_mode_t m, input logic pin);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.known = 1'b0;
    row.m = m;
    row.pin = pin;
    row.r = REG_DEBOUNCE;
    row.v = '0;
    row.want = '0;
    return row;
  endfunction

  function automatic dir_row_t known_row(input kdec_mode_t m, input logic pin,
                                         input key_state_t ks);
    dir_row_t row;
    row = item_row(m, pin);
    row.known = 1'b1;
    row.want = '0;
    row.want.key_state = ks;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input kdec_reg_t r, input logic [15:0] v);
    dir_row_t row;
    row = item_row(MODE_TICK, 1'b1);
    row.is_cfg = 1'b1;
    row.r = r;
    row.v = v;
    return row;
  endfunction

  always @(posedge clk) result_stall <= !calm && ($urandom_range(0, 99) < 26);

  always @(posedge clk) begin
    kdec_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        note_mismatch("result transfer with nothing pending", key_state, 0);
      end else begin
        want = expected_results.pop_front();
        if (key_state !== want.key_state)
          note_mismatch("key_state", key_state, want.key_state);
        if (read_value !== want.read_value)
          note_mismatch("read_value", read_value, want.read_value);
        if (press_events !== want.press_events)
          note_mismatch("press_events", press_events, want.press_events);
        if (release_events !== want.release_events)
          note_mismatch("release_events", release_events, want.release_events);
        if (timeout_events !== want.timeout_events)
          note_mismatch("timeout_events", timeout_events, want.timeout_events);
      end
    end
  end

  initial begin
    dir_row_t    rows[$];
    phase_plan_t plans[$];
    phase_plan_t p;
    int          seg_left;
    logic        seg_pin;
    int          dcap;
    int          hcap;

    key_ph = KS_RELEASED;
    tick_cnt = '0;
    mark_cnt = '0;
    n_press = '0;
    n_release = '0;
    n_timeout = '0;
    cfg_debounce = DEBOUNCE_RESET;
    cfg_hold = HOLD_RESET;

    // reads and ticks straight out of reset, with pin ignored on reads
    rows.push_back(known_row(MODE_READ_PRESS, 1'b1, KS_RELEASED));
    rows.push_back(known_row(MODE_READ_RELEASE, 1'b0, KS_RELEASED));
    rows.push_back(known_row(MODE_READ_TIMEOUT, 1'b1, KS_RELEASED));
    rows.push_back(known_row(MODE_TICK, 1'b1, KS_RELEASED));
    rows.push_back(known_row(MODE_TICK, 1'b0, KS_PRESSING));
    rows.push_back(known_row(MODE_TICK, 1'b1, KS_RELEASED));
    // zero debounce and zero hold
    rows.push_back(cfg_row(REG_DEBOUNCE, 16'd0));
    rows.push_back(cfg_row(REG_HOLD, 16'd0));
    repeat (4) rows.push_back(item_row(MODE_TICK, 1'b0));
    rows.push_back(item_row(MODE_TICK, 1'b1));
    rows.push_back(item_row(MODE_TICK, 1'b0));
    rows.push_back(item_row(MODE_READ_PRESS, 1'b1));
    rows.push_back(item_row(MODE_READ_RELEASE, 1'b0));
    rows.push_back(item_row(MODE_READ_TIMEOUT, 1'b1));
    // bounce while releasing drops back to pressed
    rows.push_back(cfg_row(REG_DEBOUNCE, 16'd1));
    rows.push_back(cfg_row(REG_HOLD, 16'd2));
    repeat (4) rows.push_back(item_row(MODE_TICK, 1'b0));
    rows.push_back(item_row(MODE_TICK, 1'b1));
    rows.push_back(item_row(MODE_TICK, 1'b0));
    rows.push_back(item_row(MODE_TICK, 1'b1));
    rows.push_back(item_row(MODE_TICK, 1'b1));
    rows.push_back(item_row(MODE_READ_TIMEOUT, 1'b0));

    plans.push_back('{4, 9, 120, 12, 1'b0});
    plans.push_back('{1, 3, 100, 10, 1'b1});
    plans.push_back('{12, 30, 120, 15, 1'b0});
    plans.push_back('{0, 0, 60, 20, 1'b0});
    // largest limits: nothing ever settles
    plans.push_back('{65535, 65535, 40, 10, 1'b0});
    plans.push_back('{$urandom_range(1, 40), $urandom_range(1, 80), 100, 12, 1'b0});
    plans.push_back('{7, 3, 80, 12, 1'b0});

    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        wait_drained();
        apb_write(rows[i].r, rows[i].v);
      end else begin
        push_item(rows[i].m, rows[i].pin, rows[i].known, rows[i].want);
      end
    end

    // no reads: each down, down, up, up cycle adds one press, one timeout
    // and one release, so all three event counts wrap
    wait_drained();
    apb_write(REG_DEBOUNCE, 16'd0);
    apb_write(REG_HOLD, 16'd0);
    repeat (260) begin
      push_item(MODE_TICK, 1'b0);
      push_item(MODE_TICK, 1'b0);
      push_item(MODE_TICK, 1'b1);
      push_item(MODE_TICK, 1'b1);
    end
    push_item(MODE_READ_PRESS, 1'b1);
    push_item(MODE_READ_RELEASE, 1'b0);
    push_item(MODE_READ_TIMEOUT, 1'b1);

    foreach (plans[i]) begin
      p = plans[i];
      wait_drained();
      apb_write(REG_DEBOUNCE, p.debounce[15:0]);
      apb_write(REG_HOLD, p.hold[15:0]);
      calm = p.calm;
      dcap = (p.debounce > 40) ? 40 : p.debounce;
      hcap = (p.hold > 60) ? 60 : p.hold;
      seg_pin = 1'b1;
      seg_left = 0;
      for (int k = 0; k < p.items; k++) begin
        if (k == p.items / 2) wait_drained();
        if ($urandom_range(0, 99) < p.read_pct) begin
          push_item(kdec_mode_t'($urandom_range(1, 3)), 1'($urandom_range(0, 1)));
        end else if ($urandom_range(0, 99) < 6) begin
          push_item(MODE_TICK, 1'($urandom_range(0, 1)));
        end else begin
          // level segments around the debounce and hold limits
          if (seg_left == 0) begin
            seg_pin = ~seg_pin;
            seg_left = seg_pin ? $urandom_range(1, 2 * dcap + 3)
                               : $urandom_range(1, dcap + 2 * hcap + 3);
          end
          push_item(MODE_TICK, seg_pin);
          seg_left--;
        end
      end
      calm = 1'b0;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
